// ===== rtl/rbps_pkg.sv =====
// Shared types, constants and register indexes for the raised bevel pixel shader.
package rbps_pkg;

   localparam int QUANTUM_BITS = 16;
   localparam int CHANNELS     = 4;
   localparam int LANES        = 4;
   localparam int CHAN_W       = 16;
   localparam int COORD_W      = 16;
   localparam int NUM_W        = CHAN_W + QUANTUM_BITS + 1;
   localparam int REM_W        = QUANTUM_BITS + 2;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 16;
   localparam int LANE_STAGES  = 4;

   localparam longint unsigned SCALE_L     = (64'd1 << QUANTUM_BITS) - 64'd1;
   localparam longint unsigned FACTOR_HI_L = (64'd190 * SCALE_L + 64'd127) / 64'd255;
   localparam longint unsigned FACTOR_LO_L = (64'd135 * SCALE_L + 64'd127) / 64'd255;

   localparam logic [QUANTUM_BITS-1:0] FULL_SCALE = QUANTUM_BITS'(SCALE_L);
   localparam logic [QUANTUM_BITS-1:0] FACTOR_HI  = QUANTUM_BITS'(FACTOR_HI_L);
   localparam logic [QUANTUM_BITS-1:0] FACTOR_LO  = QUANTUM_BITS'(FACTOR_LO_L);

   localparam logic [NUM_W-1:0] TARGET_HI   = NUM_W'(SCALE_L * (SCALE_L - FACTOR_HI_L));
   localparam logic [NUM_W-1:0] TARGET_LO   = NUM_W'(SCALE_L * (SCALE_L - FACTOR_LO_L));
   localparam logic [NUM_W-1:0] ROUND_HALF  = NUM_W'((SCALE_L - 64'd1) / 64'd2);
   localparam logic [NUM_W-1:0] CLAMP_LIMIT = NUM_W'(SCALE_L * (SCALE_L + 64'd1));

   localparam logic [REM_W-1:0] SCALE_REM = REM_W'(SCALE_L);
   localparam logic [REM_W-1:0] TWICE_REM = REM_W'(64'd2 * SCALE_L);

   typedef enum logic [2:0] {
      REGION_NONE      = 3'd0,
      REGION_HIGHLIGHT = 3'd1,
      REGION_ACCENT    = 3'd2,
      REGION_SHADOW    = 3'd3,
      REGION_TROUGH    = 3'd4
   } region_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_COLUMNS = 3'd0,
      CSR_IMAGE_ROWS    = 3'd1,
      CSR_BORDER_WIDTH  = 3'd2,
      CSR_BEVEL_HEIGHT  = 3'd3,
      CSR_RAISE_MODE    = 3'd4,
      CSR_CHANNEL_MASK  = 3'd5
   } csr_index_type;

   typedef logic [CHAN_W-1:0] chan_type;

   typedef struct packed {
      logic [COORD_W-1:0] pixel_column;
      logic [COORD_W-1:0] pixel_row;
      chan_type           chan_in_0;
      chan_type           chan_in_1;
      chan_type           chan_in_2;
      chan_type           chan_in_3;
   } req_type;

   typedef struct packed {
      chan_type   chan_out_0;
      chan_type   chan_out_1;
      chan_type   chan_out_2;
      chan_type   chan_out_3;
      logic [2:0] edge_region;
      logic       geometry_error;
   } rsp_type;

   typedef struct packed {
      logic [15:0] image_columns;
      logic [15:0] image_rows;
      logic [14:0] border_width;
      logic [14:0] bevel_height;
      logic        raise_mode;
      logic [3:0]  channel_update_mask;
   } cfg_type;

   typedef struct packed {
      logic update;
      logic factor_lo;
      logic target_full;
   } lane_ctl_type;

endpackage

// ===== rtl/rbps_classify.sv =====
// Two-stage region classifier: coordinate compares, then region and blend selection.
module rbps_classify (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    beat_in,
   input  rbps_pkg::req_type                       req_in,
   input  rbps_pkg::cfg_type                       cfg,
   output logic                                    beat_out,
   output rbps_pkg::region_type                    region_out,
   output logic                                    bad_out,
   output rbps_pkg::lane_ctl_type [rbps_pkg::LANES-1:0] ctl_out,
   output rbps_pkg::chan_type [rbps_pkg::LANES-1:0]     chan_out
);

   typedef struct packed {
      logic bad;
      logic outside;
      logic top;
      logic mid;
      logic tx_y;
      logic tx_wy;
      logic m_bw;
      logic m_wbw;
      logic b_d;
      logic b_wd;
   } flags_type;

   logic signed [17:0] x_s, y_s, w_s, h_s, bw_s, bh_s;

   flags_type flags_in, flags_ff;
   logic      v1_in, v1_ff;
   rbps_pkg::chan_type [rbps_pkg::LANES-1:0] chan1_in, chan1_ff;

   logic                   v2_in, v2_ff;
   rbps_pkg::region_type   region_in, region_ff;
   logic                   bad_in, bad_ff;
   rbps_pkg::lane_ctl_type [rbps_pkg::LANES-1:0] ctl_in, ctl_ff;
   rbps_pkg::chan_type [rbps_pkg::LANES-1:0]     chan2_ff;

   assign x_s  = $signed({2'b00, req_in.pixel_column});
   assign y_s  = $signed({2'b00, req_in.pixel_row});
   assign w_s  = $signed({2'b00, cfg.image_columns});
   assign h_s  = $signed({2'b00, cfg.image_rows});
   assign bw_s = $signed({3'b000, cfg.border_width});
   assign bh_s = $signed({3'b000, cfg.bevel_height});

   always_comb begin
      flags_in.bad     = ({1'b0, cfg.image_columns} <= {1'b0, cfg.border_width, 1'b0}) ||
                         ({1'b0, cfg.image_rows} <= {1'b0, cfg.bevel_height, 1'b0});
      flags_in.outside = (x_s >= w_s) || (y_s >= h_s);
      flags_in.top     = y_s < bh_s;
      flags_in.mid     = y_s < (h_s - bh_s);
      flags_in.tx_y    = x_s < y_s;
      flags_in.tx_wy   = x_s < (w_s - y_s);
      flags_in.m_bw    = x_s < bw_s;
      flags_in.m_wbw   = x_s >= (w_s - bw_s);
      flags_in.b_d     = x_s < (h_s - y_s);
      flags_in.b_wd    = x_s < (w_s - h_s + y_s);
   end

   assign v1_in       = beat_in;
   assign chan1_in[0] = req_in.chan_in_0;
   assign chan1_in[1] = req_in.chan_in_1;
   assign chan1_in[2] = req_in.chan_in_2;
   assign chan1_in[3] = req_in.chan_in_3;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
      end
      flags_ff <= flags_in;
      chan1_ff <= chan1_in;
   end

   always_comb begin
      if (flags_ff.bad || flags_ff.outside) begin
         region_in = rbps_pkg::REGION_NONE;
      end else if (flags_ff.top) begin
         if (flags_ff.tx_y) begin
            region_in = rbps_pkg::REGION_HIGHLIGHT;
         end else if (flags_ff.tx_wy) begin
            region_in = rbps_pkg::REGION_ACCENT;
         end else begin
            region_in = rbps_pkg::REGION_SHADOW;
         end
      end else if (flags_ff.mid) begin
         if (flags_ff.m_bw) begin
            region_in = rbps_pkg::REGION_HIGHLIGHT;
         end else if (flags_ff.m_wbw) begin
            region_in = rbps_pkg::REGION_SHADOW;
         end else begin
            region_in = rbps_pkg::REGION_NONE;
         end
      end else begin
         if (flags_ff.b_d) begin
            region_in = rbps_pkg::REGION_HIGHLIGHT;
         end else if (flags_ff.b_wd) begin
            region_in = rbps_pkg::REGION_TROUGH;
         end else begin
            region_in = rbps_pkg::REGION_SHADOW;
         end
      end
   end

   always_comb begin
      logic lo;
      logic toward_fg;
      lo        = (region_in == rbps_pkg::REGION_ACCENT) ||
                  (region_in == rbps_pkg::REGION_TROUGH);
      toward_fg = (region_in == rbps_pkg::REGION_HIGHLIGHT) ||
                  (region_in == rbps_pkg::REGION_ACCENT);
      for (int i = 0; i < rbps_pkg::LANES; i++) begin
         ctl_in[i].update      = (region_in != rbps_pkg::REGION_NONE) &&
                                 cfg.channel_update_mask[i] && (i < rbps_pkg::CHANNELS);
         ctl_in[i].factor_lo   = lo;
         ctl_in[i].target_full = toward_fg ? cfg.raise_mode : !cfg.raise_mode;
      end
   end

   assign v2_in  = v1_ff;
   assign bad_in = flags_ff.bad;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v2_in;
      end
      region_ff <= region_in;
      bad_ff    <= bad_in;
      ctl_ff    <= ctl_in;
      chan2_ff  <= chan1_ff;
   end

   assign beat_out   = v2_ff;
   assign region_out = region_ff;
   assign bad_out    = bad_ff;
   assign ctl_out    = ctl_ff;
   assign chan_out   = chan2_ff;

endmodule

// ===== rtl/rbps_lane.sv =====
// Four-stage blend lane for one channel: multiply, sum, divide by full scale, round and clamp.
module rbps_lane (
   input  logic                   clock,
   input  rbps_pkg::lane_ctl_type ctl_in,
   input  rbps_pkg::chan_type     q_in,
   output rbps_pkg::chan_type     q_out
);

   localparam int QB = rbps_pkg::QUANTUM_BITS;
   localparam int NW = rbps_pkg::NUM_W;
   localparam int RW = rbps_pkg::REM_W;

   // stage 3: product
   logic [NW-1:0]          prod_in, prod_ff;
   rbps_pkg::lane_ctl_type ctl3_ff;
   rbps_pkg::chan_type     q3_ff;

   // stage 4: rounded numerator
   logic [NW-1:0]      n2_in, n2_ff;
   logic               upd4_ff;
   rbps_pkg::chan_type q4_ff;

   // stage 5: quotient estimate and remainder
   logic [NW-1:0]      qe_full, rem_full;
   logic [QB-1:0]      qe_in, qe_ff;
   logic [RW-1:0]      rem_in, rem_ff;
   logic               clamp_in, clamp_ff;
   logic               upd5_ff;
   rbps_pkg::chan_type q5_ff;

   // stage 6: result
   logic [QB-1:0]      r_val;
   rbps_pkg::chan_type out_in, out_ff;

   always_comb begin
      logic [QB-1:0] f;
      f       = ctl_in.factor_lo ? rbps_pkg::FACTOR_LO : rbps_pkg::FACTOR_HI;
      prod_in = NW'(q_in) * NW'(f);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      ctl3_ff <= ctl_in;
      q3_ff   <= q_in;
   end

   always_comb begin
      logic [NW-1:0] tgt;
      if (!ctl3_ff.target_full) begin
         tgt = '0;
      end else if (ctl3_ff.factor_lo) begin
         tgt = rbps_pkg::TARGET_LO;
      end else begin
         tgt = rbps_pkg::TARGET_HI;
      end
      n2_in = prod_ff + tgt + rbps_pkg::ROUND_HALF;
   end

   always_ff @(posedge clock) begin
      n2_ff   <= n2_in;
      upd4_ff <= ctl3_ff.update;
      q4_ff   <= q3_ff;
   end

   // n / (2^QB - 1) estimate, low by at most one below the clamp limit
   assign qe_full  = (n2_ff + (n2_ff >> QB)) >> QB;
   assign rem_full = n2_ff - ((qe_full << QB) - qe_full);
   assign qe_in    = qe_full[QB-1:0];
   assign rem_in   = rem_full[RW-1:0];
   assign clamp_in = n2_ff >= rbps_pkg::CLAMP_LIMIT;

   always_ff @(posedge clock) begin
      qe_ff    <= qe_in;
      rem_ff   <= rem_in;
      clamp_ff <= clamp_in;
      upd5_ff  <= upd4_ff;
      q5_ff    <= q4_ff;
   end

   assign r_val = qe_ff + QB'(rem_ff >= rbps_pkg::SCALE_REM) +
                  QB'(rem_ff >= rbps_pkg::TWICE_REM);

   always_comb begin
      if (!upd5_ff) begin
         out_in = q5_ff;
      end else if (clamp_ff) begin
         out_in = rbps_pkg::CHAN_W'(rbps_pkg::FULL_SCALE);
      end else begin
         out_in = rbps_pkg::CHAN_W'(r_val);
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign q_out = out_ff;

endmodule

// ===== rtl/raised_bevel_pixel_shader_unit.sv =====
// Top level of the raised bevel pixel shader: registers, classifier, blend lanes, result.
//
//   channel   ports                                          direction
//   request   start, busy, req_data                          in  (busy out)
//   result    rsp_strobe, rsp_data                           out
//   config    csr_write_enable, csr_index, csr_write_data    in
//
// One pixel per clock; busy is always low. The result is registered through
// two classifier stages and four lane stages (multiply, sum, divide, round and clamp).
// Synchronous active-high reset clears valid bits and loads register defaults.
// The result strobe lasts one cycle; there is no back-pressure.
module raised_bevel_pixel_shader_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  rbps_pkg::req_type                   req_data,
   output logic                                rsp_strobe,
   output rbps_pkg::rsp_type                   rsp_data,
   input  logic                                csr_write_enable,
   input  logic [rbps_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rbps_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   localparam int DL = rbps_pkg::LANE_STAGES;

   rbps_pkg::cfg_type cfg_in, cfg_ff;

   logic                   accept;
   logic                   cls_beat;
   rbps_pkg::region_type   cls_region;
   logic                   cls_bad;
   rbps_pkg::lane_ctl_type [rbps_pkg::LANES-1:0] cls_ctl;
   rbps_pkg::chan_type [rbps_pkg::LANES-1:0]     cls_chan;
   rbps_pkg::chan_type [rbps_pkg::LANES-1:0]     lane_out;

   logic [DL-1:0]        vld_in, vld_ff;
   logic [DL-1:0][2:0]   region_in, region_ff;
   logic [DL-1:0]        bad_in, bad_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            rbps_pkg::CSR_IMAGE_COLUMNS: cfg_in.image_columns = csr_write_data;
            rbps_pkg::CSR_IMAGE_ROWS:    cfg_in.image_rows    = csr_write_data;
            rbps_pkg::CSR_BORDER_WIDTH:  cfg_in.border_width  = csr_write_data[14:0];
            rbps_pkg::CSR_BEVEL_HEIGHT:  cfg_in.bevel_height  = csr_write_data[14:0];
            rbps_pkg::CSR_RAISE_MODE:    cfg_in.raise_mode    = csr_write_data[0];
            rbps_pkg::CSR_CHANNEL_MASK:  cfg_in.channel_update_mask = csr_write_data[3:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_columns       <= 16'd640;
         cfg_ff.image_rows          <= 16'd480;
         cfg_ff.border_width        <= 15'd6;
         cfg_ff.bevel_height        <= 15'd6;
         cfg_ff.raise_mode          <= 1'b1;
         cfg_ff.channel_update_mask <= 4'hF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rbps_classify u_classify (
      .clock      (clock),
      .reset      (reset),
      .beat_in    (accept),
      .req_in     (req_data),
      .cfg        (cfg_ff),
      .beat_out   (cls_beat),
      .region_out (cls_region),
      .bad_out    (cls_bad),
      .ctl_out    (cls_ctl),
      .chan_out   (cls_chan)
   );

   for (genvar i = 0; i < rbps_pkg::LANES; i++) begin : g_lane
      rbps_lane u_lane (
         .clock  (clock),
         .ctl_in (cls_ctl[i]),
         .q_in   (cls_chan[i]),
         .q_out  (lane_out[i])
      );
   end

   // region and error ride alongside the lanes
   always_comb begin
      vld_in[0]    = cls_beat;
      region_in[0] = cls_region;
      bad_in[0]    = cls_bad;
      for (int s = 1; s < DL; s++) begin
         vld_in[s]    = vld_ff[s-1];
         region_in[s] = region_ff[s-1];
         bad_in[s]    = bad_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      region_ff <= region_in;
      bad_ff    <= bad_in;
   end

   assign rsp_strobe              = vld_ff[DL-1];
   assign rsp_data.chan_out_0     = lane_out[0];
   assign rsp_data.chan_out_1     = lane_out[1];
   assign rsp_data.chan_out_2     = lane_out[2];
   assign rsp_data.chan_out_3     = lane_out[3];
   assign rsp_data.edge_region    = region_ff[DL-1];
   assign rsp_data.geometry_error = bad_ff[DL-1];

endmodule
